### src/fqaa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the four-queue aging arbiter.
package fqaa_pkg;

    localparam int LANES      = 4;
    localparam int LANE_W     = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int WAIT_LIM_W = 16;
    localparam int CNT_LIM_W  = 5;
    localparam int WAIT_OUT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_LIMIT  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LIMIT = 8'd1;

    localparam logic [WAIT_LIM_W-1:0] WAIT_LIMIT_RESET  = 16'd20;
    localparam logic [CNT_LIM_W-1:0]  COUNT_LIMIT_RESET = 5'd5;

    typedef enum logic [2:0] {
        DEC_WAIT  = 3'd0,
        DEC_COUNT = 3'd1,
        DEC_STAY  = 3'd2,
        DEC_NEW   = 3'd3,
        DEC_IDLE  = 3'd4
    } decision_t;

    // per-tick control into one lane
    typedef struct packed {
        logic step;
        logic arrive;
    } lane_ctrl_t;

    typedef struct packed {
        logic                  grant_valid;
        logic [LANE_W-1:0]     grant_lane;
        logic [WAIT_OUT_W-1:0] served_wait;
        decision_t             decision;
        logic [LANES-1:0]      dropped;
        logic                  honk;
    } result_t;

endpackage

### src/fqaa_stamp_ram.sv
`timescale 1ns / 1ps
// Single-port-write, registered-read stamp memory for one lane.
module fqaa_stamp_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // write-first: a read of the slot being written returns the new stamp
    always_ff @(posedge aclk) begin
        if (we && (waddr == raddr)) begin
            rdata_reg <= wdata;
        end else begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/fqaa_lane.sv
`timescale 1ns / 1ps
// One FIFO lane: pointers, occupancy, two-entry head cache and its stamp memory.
module fqaa_lane #(
    parameter int QUEUE_DEPTH = 16,
    parameter int STAMP_WIDTH = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  fqaa_pkg::lane_ctrl_t             ctrl,
    input  logic                             pop,
    input  logic [STAMP_WIDTH-1:0]           tick_time,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] count_after,
    output logic [STAMP_WIDTH-1:0]           head_stamp,
    output logic                             full
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [CW-1:0]          count_reg, count_next;
    logic [PW-1:0]          head_reg, head_next;
    logic [PW-1:0]          tail_reg, tail_next;
    logic [STAMP_WIDTH-1:0] h0_reg, h0_next;
    logic [STAMP_WIDTH-1:0] h1_reg, h1_next;
    logic [STAMP_WIDTH-1:0] ram_rdata;
    logic [STAMP_WIDTH-1:0] e0, e1, e2;
    logic [PW:0]            raddr_sum;
    logic [PW-1:0]          raddr;
    logic                   push;
    logic                   do_pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        full        = (count_reg == CW'(QUEUE_DEPTH));
        push        = ctrl.step && ctrl.arrive && !full;
        do_pop      = ctrl.step && pop;
        count_after = count_reg + CW'(push);

        // entries by place from the head, with this tick's arrival merged in
        e0 = (count_reg == '0)     ? tick_time : h0_reg;
        e1 = (count_reg == CW'(1) && push) ? tick_time : h1_reg;
        e2 = (count_reg == CW'(2) && push) ? tick_time : ram_rdata;
        head_stamp = e0;

        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        h0_next    = h0_reg;
        h1_next    = h1_reg;
        if (ctrl.step) begin
            count_next = count_after - CW'(do_pop);
            head_next  = do_pop ? ptr_inc(head_reg) : head_reg;
            tail_next  = push ? ptr_inc(tail_reg) : tail_reg;
            h0_next    = do_pop ? e1 : e0;
            h1_next    = do_pop ? e2 : e1;
        end

        // prefetch the third entry of the next state
        raddr_sum = {1'b0, head_next} + (PW + 1)'(2);
        if (raddr_sum >= (PW + 1)'(QUEUE_DEPTH)) begin
            raddr_sum = raddr_sum - (PW + 1)'(QUEUE_DEPTH);
        end
        raddr = raddr_sum[PW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
        end else begin
            count_reg <= count_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
        end
    end

    always_ff @(posedge aclk) begin
        h0_reg <= h0_next;
        h1_reg <= h1_next;
    end

    fqaa_stamp_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (STAMP_WIDTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (push),
        .waddr (tail_reg),
        .wdata (tick_time),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

endmodule

### src/fqaa_result_buf.sv
`timescale 1ns / 1ps
// Two-entry output buffer that parts the tick side from the result side.
module fqaa_result_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  fqaa_pkg::result_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output fqaa_pkg::result_t out_data
);

    logic              v0_reg, v0_next;
    logic              v1_reg, v1_next;
    fqaa_pkg::result_t e0_reg, e0_next;
    fqaa_pkg::result_t e1_reg, e1_next;
    logic              push;
    logic              pull;

    always_comb begin
        in_ready  = !v1_reg;
        out_valid = v0_reg;
        out_data  = e0_reg;
        push      = in_valid && !v1_reg;
        pull      = v0_reg && out_ready;

        v0_next = v0_reg;
        v1_next = v1_reg;
        e0_next = e0_reg;
        e1_next = e1_reg;
        if (pull) begin
            if (v1_reg) begin
                e0_next = e1_reg;
                v1_next = push;
                e1_next = in_data;
            end else begin
                v0_next = push;
                e0_next = in_data;
            end
        end else if (!v0_reg) begin
            v0_next = push;
            e0_next = in_data;
        end else if (push) begin
            v1_next = 1'b1;
            e1_next = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge aclk) begin
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

endmodule

### src/four_queue_aging_arbiter_unit.sv
`timescale 1ns / 1ps
// Top level of the four-queue aging arbiter: lanes, selection, tick state, config.
//
// Usage:
//   Input channel (s_valid/s_ready/s_arrivals): one transaction is one time tick;
//   bit 0..3 pushes an entry into the N, E, S, W queue, stamped with the tick time.
//   Result channel (m_*): exactly one transaction per tick, in tick order, giving
//   the served lane, its wait, the selection rule, refused arrivals and honk.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 writes the
//   wait limit, index 1 the count limit; always ready, write only while idle.
// Timing:
//   One tick per cycle sustained while s_ready is high. Each tick's result is
//   registered into the output buffer, while the selection over the four lanes
//   and the winning lane's head-cache update complete in the acceptance cycle.
//   Each lane keeps its two oldest stamps in registers and prefetches the third
//   from its stamp memory, so back-to-back pops never wait on the memory read.
// Reset (aresetn low, synchronous): queues empty, tick time zero, limits back to
//   20 and 5, no last lane. No clearing pass: stamp memory is read only where
//   written. When the receiver stalls, a two-entry output buffer holds results;
//   s_ready drops only once both entries are full.
module four_queue_aging_arbiter_unit #(
    parameter int QUEUE_DEPTH = 16,
    parameter int STAMP_WIDTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [fqaa_pkg::LANES-1:0]            s_arrivals,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_grant_valid,
    output logic [fqaa_pkg::LANE_W-1:0]           m_grant_lane,
    output logic [fqaa_pkg::WAIT_OUT_W-1:0]       m_served_wait,
    output logic [2:0]                            m_decision,
    output logic [fqaa_pkg::LANES-1:0]            m_dropped,
    output logic                                  m_honk,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fqaa_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fqaa_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int CLW  = (CW > fqaa_pkg::CNT_LIM_W) ? CW : fqaa_pkg::CNT_LIM_W;
    localparam int CMPW = (STAMP_WIDTH > fqaa_pkg::WAIT_LIM_W) ? STAMP_WIDTH
                                                                 : fqaa_pkg::WAIT_LIM_W;

    // configuration
    logic [fqaa_pkg::WAIT_LIM_W-1:0] wait_limit_reg;
    logic [fqaa_pkg::CNT_LIM_W-1:0]  count_limit_reg;

    // tick state
    logic [STAMP_WIDTH-1:0]       tick_time_reg, tick_time_next;
    logic                         idle_flag_reg, idle_flag_next;
    logic                         last_valid_reg, last_valid_next;
    logic [fqaa_pkg::LANE_W-1:0]  last_lane_reg, last_lane_next;

    // lane interface
    fqaa_pkg::lane_ctrl_t         ctrl     [fqaa_pkg::LANES];
    logic [CW-1:0]                cnt_after[fqaa_pkg::LANES];
    logic [STAMP_WIDTH-1:0]       head_stamp[fqaa_pkg::LANES];
    logic [fqaa_pkg::LANES-1:0]   full;
    logic [fqaa_pkg::LANES-1:0]   pop_vec;

    // selection
    logic                         step;
    logic                         honk;
    logic                         last_valid_eff;
    logic                         any;
    logic [STAMP_WIDTH-1:0]       head_wait[fqaa_pkg::LANES];
    logic [STAMP_WIDTH-1:0]       best_wait;
    logic [fqaa_pkg::LANE_W-1:0]  wait_lane;
    logic                         found;
    logic [CW-1:0]                best_cnt;
    logic [fqaa_pkg::LANE_W-1:0]  cnt_lane;
    logic [fqaa_pkg::LANE_W-1:0]  lane;
    fqaa_pkg::decision_t          decision;
    fqaa_pkg::result_t            result;
    fqaa_pkg::result_t            out_data;
    logic                         buf_ready;

    assign cfg_ready = 1'b1;
    assign s_ready   = buf_ready;
    assign step      = s_valid && buf_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wait_limit_reg  <= fqaa_pkg::WAIT_LIMIT_RESET;
            count_limit_reg <= fqaa_pkg::COUNT_LIMIT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                fqaa_pkg::CFG_WAIT_LIMIT: begin
                    wait_limit_reg <= cfg_data;
                end
                fqaa_pkg::CFG_COUNT_LIMIT: begin
                    count_limit_reg <= cfg_data[fqaa_pkg::CNT_LIM_W-1:0];
                end
                default: begin
                    // no register here: drop the write
                end
            endcase
        end
    end

    for (genvar g = 0; g < fqaa_pkg::LANES; g++) begin : g_lane
        assign ctrl[g].step   = step;
        assign ctrl[g].arrive = s_arrivals[g];

        fqaa_lane #(
            .QUEUE_DEPTH (QUEUE_DEPTH),
            .STAMP_WIDTH (STAMP_WIDTH)
        ) u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl[g]),
            .pop         (pop_vec[g]),
            .tick_time   (tick_time_reg),
            .count_after (cnt_after[g]),
            .head_stamp  (head_stamp[g]),
            .full        (full[g])
        );
    end

    always_comb begin
        // a tick after an idle one with any arrival honks and forgets the last lane
        honk           = idle_flag_reg && (s_arrivals != '0);
        last_valid_eff = last_valid_reg && !honk;

        any = 1'b0;
        for (int q = 0; q < fqaa_pkg::LANES; q++) begin
            head_wait[q] = tick_time_reg - head_stamp[q];
            any          = any || (cnt_after[q] != '0);
        end

        // oldest nonempty head, ties to the lower lane
        best_wait = '0;
        wait_lane = '0;
        found     = 1'b0;
        for (int q = 0; q < fqaa_pkg::LANES; q++) begin
            if ((cnt_after[q] != '0) && (!found || (head_wait[q] > best_wait))) begin
                best_wait = head_wait[q];
                wait_lane = fqaa_pkg::LANE_W'(q);
                found     = 1'b1;
            end
        end

        // fullest lane, ties to the lower lane
        best_cnt = '0;
        cnt_lane = '0;
        for (int q = 0; q < fqaa_pkg::LANES; q++) begin
            if (cnt_after[q] > best_cnt) begin
                best_cnt = cnt_after[q];
                cnt_lane = fqaa_pkg::LANE_W'(q);
            end
        end

        if (!any) begin
            lane     = '0;
            decision = fqaa_pkg::DEC_IDLE;
        end else if (CMPW'(best_wait) >= CMPW'(wait_limit_reg)) begin
            lane     = wait_lane;
            decision = fqaa_pkg::DEC_WAIT;
        end else if (CLW'(best_cnt) >= CLW'(count_limit_reg)) begin
            lane     = cnt_lane;
            decision = fqaa_pkg::DEC_COUNT;
        end else if (last_valid_eff && (cnt_after[last_lane_reg] != '0)) begin
            lane     = last_lane_reg;
            decision = fqaa_pkg::DEC_STAY;
        end else begin
            lane     = cnt_lane;
            decision = fqaa_pkg::DEC_NEW;
        end

        pop_vec = '0;
        if (any) begin
            pop_vec[lane] = 1'b1;
        end

        result.grant_valid = any;
        result.grant_lane  = lane;
        result.served_wait = any ? fqaa_pkg::WAIT_OUT_W'(head_wait[lane]) : '0;
        result.decision    = decision;
        result.dropped     = full & s_arrivals;
        result.honk        = honk;

        // advance tick state on each accepted transaction
        tick_time_next  = tick_time_reg;
        idle_flag_next  = idle_flag_reg;
        last_valid_next = last_valid_reg;
        last_lane_next  = last_lane_reg;
        if (step) begin
            tick_time_next = tick_time_reg + 1'b1;
            if (any) begin
                idle_flag_next  = 1'b0;
                last_valid_next = 1'b1;
                last_lane_next  = lane;
            end else begin
                idle_flag_next  = 1'b1;
                last_valid_next = last_valid_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_time_reg  <= '0;
            idle_flag_reg  <= 1'b0;
            last_valid_reg <= 1'b0;
            last_lane_reg  <= '0;
        end else begin
            tick_time_reg  <= tick_time_next;
            idle_flag_reg  <= idle_flag_next;
            last_valid_reg <= last_valid_next;
            last_lane_reg  <= last_lane_next;
        end
    end

    fqaa_result_buf u_result_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (buf_ready),
        .in_data   (result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_grant_valid = out_data.grant_valid;
    assign m_grant_lane  = out_data.grant_lane;
    assign m_served_wait = out_data.served_wait;
    assign m_decision    = out_data.decision;
    assign m_dropped     = out_data.dropped;
    assign m_honk        = out_data.honk;

`ifndef ASSERT_OFF
    // a grant always pops a lane that holds an entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        step && any |-> cnt_after[lane] != '0)
        else $error("grant to an empty lane");

    // at most one lane pops per tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(pop_vec))
        else $error("more than one lane popped");

    // honk comes only with a grant: the honking arrival cannot have been dropped
    assert property (@(posedge aclk) disable iff (!aresetn)
        step && honk |-> any && (full == '0))
        else $error("honk without a grant");

    // tick time advances by exactly one per accepted tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> tick_time_reg == STAMP_WIDTH'($past(tick_time_reg) + 1'b1))
        else $error("tick time did not advance");
`endif

endmodule
